### hdl/cor_pkg.sv
// Package with the types and constants that the circle octant rasterizer files share.
`default_nettype none
package cor_pkg;

   localparam int IMG_WIDTH  = 1024;
   localparam int IMG_HEIGHT = 1024;
   localparam int COORD_BITS = 12;
   localparam int PIX_BITS   = 10;

   // Differences of two coordinates, their squares and the pixel sums.
   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int MUL_BITS  = DIFF_BITS + 1;
   localparam int PROD_BITS = 2 * MUL_BITS;
   localparam int RSQ_BITS  = 2 * DIFF_BITS;
   localparam int SUM_BITS  = DIFF_BITS + 2;

   localparam logic MODE_START = 1'b0;
   localparam logic MODE_STEP  = 1'b1;

   typedef struct packed {
      logic                         mode;
      logic signed [COORD_BITS-1:0] centre_x;
      logic signed [COORD_BITS-1:0] centre_y;
      logic signed [COORD_BITS-1:0] edge_x;
      logic signed [COORD_BITS-1:0] edge_y;
   } req_type;

   typedef struct packed {
      logic [PIX_BITS-1:0] pixel_x;
      logic [PIX_BITS-1:0] pixel_y;
      logic                visible;
      logic                last_of_step;
      logic                circle_done;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_start;  // capture centre and edge differences
      logic sq_x;        // square the column difference
      logic sq_y;        // square the row difference and form the squared radius
      logic load_rem;    // form R2 - x*x and arm the square root
      logic load_done;   // decide whether this column is the last one
      logic root_step;   // one square root iteration
      logic emit_adv;    // move to the next of the eight pixels
      logic finish;      // close the column step
   } cmd_type;

   typedef struct packed {
      logic active;
      logic root_last;
      logic pix_last;
   } status_type;

endpackage
`default_nettype wire

### hdl/cor_ctrl.sv
// Controller state machine that sequences start and column-step transactions.
`default_nettype none
module cor_ctrl
   import cor_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       req_mode,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_SQX  = 7'b0000010,
      ST_SQY  = 7'b0000100,
      ST_XX   = 7'b0001000,
      ST_NX   = 7'b0010000,
      ST_ROOT = 7'b0100000,
      ST_EMIT = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_mode == MODE_START) begin
                  cmd.load_start = 1'b1;
                  state_in       = ST_SQX;
               end else if (status.active) begin
                  state_in = ST_XX;
               end
            end
         end
         ST_SQX: begin
            cmd.sq_x = 1'b1;
            state_in = ST_SQY;
         end
         ST_SQY: begin
            cmd.sq_y = 1'b1;
            state_in = ST_IDLE;
         end
         ST_XX: begin
            cmd.load_rem = 1'b1;
            state_in     = ST_NX;
         end
         ST_NX: begin
            cmd.load_done = 1'b1;
            state_in      = ST_ROOT;
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            if (status.root_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               if (status.pix_last) begin
                  cmd.finish = 1'b1;
                  state_in   = ST_IDLE;
               end else begin
                  cmd.emit_adv = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

### hdl/cor_dp.sv
// Datapath: circle state, shared squarer, bit-pair square root and pixel generation.
`default_nettype none
module cor_dp
   import cor_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cmd_type cmd,
   input  wire req_type req_data,
   output status_type   status,
   output rsp_type      rsp_data
);

   logic signed [COORD_BITS-1:0] centre_col_ff;
   logic signed [COORD_BITS-1:0] centre_row_ff;
   logic signed [DIFF_BITS-1:0]  dx_ff;
   logic signed [DIFF_BITS-1:0]  dy_ff;
   logic [RSQ_BITS-1:0]          acc_ff;
   logic [RSQ_BITS-1:0]          radius_squared_ff;
   logic [DIFF_BITS-1:0]         column_index_ff;
   logic                         active_ff;
   logic [RSQ_BITS-1:0]          rem_ff;
   logic [RSQ_BITS-1:0]          root_ff;
   logic [RSQ_BITS-1:0]          bit_ff;
   logic                         done_ff;
   logic [2:0]                   pix_idx_ff;

   logic signed [MUL_BITS-1:0]   mul_op;
   logic signed [PROD_BITS-1:0]  prod_full;
   logic [RSQ_BITS-1:0]          prod;
   logic [RSQ_BITS-1:0]          sq_sum;
   logic [RSQ_BITS:0]            trial;
   logic [DIFF_BITS-1:0]         row_offset;
   logic [DIFF_BITS-1:0]         off_a;
   logic [DIFF_BITS-1:0]         off_b;
   logic signed [SUM_BITS-1:0]   col;
   logic signed [SUM_BITS-1:0]   row;
   logic                         vis;

   // One squarer serves both radius terms and both column terms.
   always_comb begin
      if (cmd.sq_x) begin
         mul_op = MUL_BITS'(dx_ff);
      end else if (cmd.sq_y) begin
         mul_op = MUL_BITS'(dy_ff);
      end else if (cmd.load_rem) begin
         mul_op = $signed({1'b0, column_index_ff});
      end else begin
         mul_op = $signed({1'b0, column_index_ff} + MUL_BITS'(1));
      end
   end

   assign prod_full = mul_op * mul_op;
   assign prod      = prod_full[RSQ_BITS-1:0];
   assign sq_sum    = acc_ff + prod;
   assign trial     = {1'b0, root_ff} + {1'b0, bit_ff};

   assign row_offset = root_ff[DIFF_BITS-1:0];

   // Bit 2 swaps the roles of x and y, bit 0 mirrors the column, bit 1 the row.
   assign off_a = pix_idx_ff[2] ? row_offset : column_index_ff;
   assign off_b = pix_idx_ff[2] ? column_index_ff : row_offset;

   always_comb begin
      if (pix_idx_ff[0]) begin
         col = SUM_BITS'(centre_col_ff) - $signed({2'b00, off_a});
      end else begin
         col = SUM_BITS'(centre_col_ff) + $signed({2'b00, off_a});
      end
      if (pix_idx_ff[1]) begin
         row = SUM_BITS'(centre_row_ff) - $signed({2'b00, off_b});
      end else begin
         row = SUM_BITS'(centre_row_ff) + $signed({2'b00, off_b});
      end
   end

   assign vis = (col >= 0) && (row >= 0) &&
                (col < SUM_BITS'(IMG_WIDTH)) && (row < SUM_BITS'(IMG_HEIGHT));

   assign rsp_data.pixel_x      = vis ? col[PIX_BITS-1:0] : '0;
   assign rsp_data.pixel_y      = vis ? row[PIX_BITS-1:0] : '0;
   assign rsp_data.visible      = vis;
   assign rsp_data.last_of_step = (pix_idx_ff == 3'd7);
   assign rsp_data.circle_done  = done_ff;

   assign status.active    = active_ff;
   assign status.root_last = bit_ff[0];
   assign status.pix_last  = (pix_idx_ff == 3'd7);

   always_ff @(posedge clock) begin
      if (reset) begin
         centre_col_ff     <= '0;
         centre_row_ff     <= '0;
         radius_squared_ff <= '0;
         column_index_ff   <= '0;
         root_ff           <= '0;
         active_ff         <= 1'b0;
      end else begin
         if (cmd.load_start) begin
            centre_col_ff   <= req_data.centre_x;
            centre_row_ff   <= req_data.centre_y;
            column_index_ff <= '0;
            root_ff         <= '0;
            active_ff       <= 1'b0;
         end
         if (cmd.sq_y) begin
            radius_squared_ff <= sq_sum;
            active_ff         <= (sq_sum != '0);
         end
         if (cmd.load_rem) begin
            root_ff <= '0;
         end
         if (cmd.root_step) begin
            if ({1'b0, rem_ff} >= trial) begin
               root_ff <= (root_ff >> 1) + bit_ff;
            end else begin
               root_ff <= root_ff >> 1;
            end
         end
         if (cmd.finish) begin
            if (done_ff) begin
               active_ff <= 1'b0;
            end else begin
               column_index_ff <= column_index_ff + DIFF_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_start) begin
         dx_ff <= DIFF_BITS'(req_data.edge_x) - DIFF_BITS'(req_data.centre_x);
         dy_ff <= DIFF_BITS'(req_data.edge_y) - DIFF_BITS'(req_data.centre_y);
      end
      if (cmd.sq_x) begin
         acc_ff <= prod;
      end
      if (cmd.load_rem) begin
         rem_ff     <= radius_squared_ff - prod;
         bit_ff     <= RSQ_BITS'(1) << (RSQ_BITS - 2);
         pix_idx_ff <= 3'd0;
      end
      if (cmd.load_done) begin
         done_ff <= {prod, 1'b0} >= {1'b0, radius_squared_ff};
      end
      if (cmd.root_step) begin
         if ({1'b0, rem_ff} >= trial) begin
            rem_ff <= rem_ff - trial[RSQ_BITS-1:0];
         end
         bit_ff <= bit_ff >> 2;
      end
      if (cmd.emit_adv) begin
         pix_idx_ff <= pix_idx_ff + 3'd1;
      end
   end

endmodule
`default_nettype wire

### hdl/circle_octant_rasterizer.sv
// Top level of the circle octant rasterizer: controller plus datapath.
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_ready  | req_data (req_type)
//   rsp     | out       | rsp_valid / rsp_ready  | rsp_data (rsp_type)
//
// A start transaction captures the request, then makes two passes of the shared squarer.
// A column step after acceptance makes two squarer passes, one square root iteration
// per result bit pair, then emits one pixel per cycle while rsp_ready.
// A step with no circle in progress is accepted and yields nothing.
// Synchronous reset returns the controller to idle and clears the circle state.
// A stall on rsp holds the current pixel; no request is taken until the step ends.
`default_nettype none
module circle_octant_rasterizer
   import cor_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   cmd_type    cmd;
   status_type status;

   cor_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_data.mode),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   cor_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule
`default_nettype wire

### hdl/cor_checker.sv
// Port-level assertions for the circle octant rasterizer and their bind.
`default_nettype none
module cor_checker
   import cor_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp transaction changed while stalled");

   a_no_req_during_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while a pixel is pending");

   a_start_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.mode == MODE_START |=> !rsp_valid)
      else $error("start transaction produced a pixel");

   a_invisible_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.visible |-> rsp_data.pixel_x == '0 && rsp_data.pixel_y == '0)
      else $error("invisible pixel carries nonzero coordinates");

   a_step_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_data.last_of_step |=> !rsp_valid && req_ready)
      else $error("pixels continued after the eighth of a step");

endmodule

bind circle_octant_rasterizer cor_checker u_cor_checker (.*);
`default_nettype wire
